[hw/rtl/ir_pulse_width_frame_decoder_defines.svh]
// Assertion macros shared by the IR pulse-width frame decoder RTL.
`ifndef IR_PULSE_WIDTH_FRAME_DECODER_DEFINES_SVH
`define IR_PULSE_WIDTH_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define IRPWD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define IRPWD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/irpwd_pkg.sv]
// Shared types, constants and helpers for the IR pulse-width frame decoder.
`default_nettype none

package irpwd_pkg;

    // Protocol constants
    localparam int MIN_BITS        = 12;
    localparam int VALUE_WIDTH     = 32;
    localparam int DUR_W           = 16;
    localparam int ITEM_W          = 8;
    localparam int PAIR_W          = 7;
    localparam int MIN_FRAME_ITEMS = 2 * MIN_BITS + 2;

    localparam logic [ITEM_W-1:0] ITEM_MAX = {ITEM_W{1'b1}};
    localparam logic [PAIR_W-1:0] PAIR_MAX = {PAIR_W{1'b1}};

    // Configuration register file
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_HDR_MARK  = 3'd0,
        REG_HDR_SPACE = 3'd1,
        REG_ONE_MARK  = 3'd2,
        REG_ZERO_MARK = 3'd3,
        REG_REPEAT    = 3'd4
    } reg_index_t;

    localparam logic [31:0] HDR_MARK_RESET  = 32'd5963830;
    localparam logic [31:0] HDR_SPACE_RESET = 32'd1441804;
    localparam logic [31:0] ONE_MARK_RESET  = 32'd4128805;
    localparam logic [31:0] ZERO_MARK_RESET = 32'd1376268;
    localparam logic [15:0] REPEAT_RESET    = 16'd16;

    // Window hits of one duration, independent of frame position
    typedef struct packed {
        logic short_gap;
        logic hdr_mark;
        logic space_ok;
        logic one_ok;
        logic zero_ok;
        logic last;
    } item_class_t;

    // Queue geometry
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;
    localparam int QCNT_W      = QUEUE_AW + 1;

    typedef enum logic [3:0] {
        ST_RUN    = 4'b0001,
        ST_STOP   = 4'b0010,
        ST_FAIL   = 4'b0100,
        ST_REPEAT = 4'b1000
    } frame_status_t;

    // Inclusive window test: low bound in 15:0, high bound in 31:16
    function automatic logic in_window(logic [31:0] win, logic [DUR_W-1:0] d);
        return (d >= win[15:0]) && (d <= win[31:16]);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/irpwd_front.sv]
// Front end: configuration registers and window classification of each duration.
`default_nettype none

module irpwd_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [irpwd_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [irpwd_pkg::DATA_W-1:0]       pwdata,
    output logic      [irpwd_pkg::DATA_W-1:0]       prdata,
    output logic                                    pready,
    input  wire logic [irpwd_pkg::DUR_W-1:0]        duration_ticks,
    input  wire logic                               last_item,
    output irpwd_pkg::item_class_t                  item_class
);

    logic [31:0] hdr_mark_win_reg;
    logic [31:0] hdr_space_win_reg;
    logic [31:0] one_mark_win_reg;
    logic [31:0] zero_mark_win_reg;
    logic [15:0] repeat_limit_reg;
    logic        wr_en;
    logic [2:0]  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];

    // Write the selected register; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_mark_win_reg  <= irpwd_pkg::HDR_MARK_RESET;
            hdr_space_win_reg <= irpwd_pkg::HDR_SPACE_RESET;
            one_mark_win_reg  <= irpwd_pkg::ONE_MARK_RESET;
            zero_mark_win_reg <= irpwd_pkg::ZERO_MARK_RESET;
            repeat_limit_reg  <= irpwd_pkg::REPEAT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                irpwd_pkg::REG_HDR_MARK:  hdr_mark_win_reg  <= pwdata;
                irpwd_pkg::REG_HDR_SPACE: hdr_space_win_reg <= pwdata;
                irpwd_pkg::REG_ONE_MARK:  one_mark_win_reg  <= pwdata;
                irpwd_pkg::REG_ZERO_MARK: zero_mark_win_reg <= pwdata;
                irpwd_pkg::REG_REPEAT:    repeat_limit_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_sel)
            irpwd_pkg::REG_HDR_MARK:  prdata = hdr_mark_win_reg;
            irpwd_pkg::REG_HDR_SPACE: prdata = hdr_space_win_reg;
            irpwd_pkg::REG_ONE_MARK:  prdata = one_mark_win_reg;
            irpwd_pkg::REG_ZERO_MARK: prdata = zero_mark_win_reg;
            irpwd_pkg::REG_REPEAT:    prdata = {16'd0, repeat_limit_reg};
            default:                  prdata = '0;
        endcase
    end

    // Classify the incoming duration against every window at once
    always_comb
    begin
        item_class.short_gap = duration_ticks < repeat_limit_reg;
        item_class.hdr_mark  = irpwd_pkg::in_window(hdr_mark_win_reg, duration_ticks);
        item_class.space_ok  = irpwd_pkg::in_window(hdr_space_win_reg, duration_ticks);
        item_class.one_ok    = irpwd_pkg::in_window(one_mark_win_reg, duration_ticks);
        item_class.zero_ok   = irpwd_pkg::in_window(zero_mark_win_reg, duration_ticks);
        item_class.last      = last_item;
    end

endmodule

`default_nettype wire

[hw/rtl/irpwd_queue.sv]
// Two-entry queue of classified items between front and back ends.
`default_nettype none

`include "ir_pulse_width_frame_decoder_defines.svh"

module irpwd_queue (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire irpwd_pkg::item_class_t   push_data,
    output logic                          not_full,
    output logic                          pop_valid,
    input  wire logic                     pop,
    output irpwd_pkg::item_class_t        pop_data
);

    irpwd_pkg::item_class_t                entry_reg [irpwd_pkg::QUEUE_DEPTH];
    logic [irpwd_pkg::QUEUE_AW-1:0]        wr_ptr_reg;
    logic [irpwd_pkg::QUEUE_AW-1:0]        rd_ptr_reg;
    logic [irpwd_pkg::QCNT_W-1:0]          count_reg;
    logic [irpwd_pkg::QCNT_W-1:0]          count_next;

    assign not_full  = count_reg != irpwd_pkg::QCNT_W'(irpwd_pkg::QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    `IRPWD_ASSERT_IMP(a_count_bound,
        1'b1, count_reg <= irpwd_pkg::QCNT_W'(irpwd_pkg::QUEUE_DEPTH),
        "queue count exceeds depth")
    `IRPWD_ASSERT_NXT(a_count_grow,
        push && !pop, count_reg == ($past(count_reg) + 1'b1),
        "queue count did not grow on push")
    `IRPWD_ASSERT_IMP(a_push_room,
        push, not_full,
        "push into a full queue")

endmodule

`default_nettype wire

[hw/rtl/irpwd_back.sv]
// Back end: frame sequencing, bit assembly and result register.
`default_nettype none

`include "ir_pulse_width_frame_decoder_defines.svh"

module irpwd_back (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  item_valid,
    input  wire irpwd_pkg::item_class_t                item,
    output logic                                       item_pop,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       decoded,
    output logic                                       is_repeat,
    output logic [irpwd_pkg::PAIR_W-1:0]               bit_count,
    output logic [irpwd_pkg::VALUE_WIDTH-1:0]          code_value
);

    localparam int W = irpwd_pkg::VALUE_WIDTH;

    logic [irpwd_pkg::ITEM_W-1:0]  item_index_reg, item_index_next;
    logic [irpwd_pkg::PAIR_W-1:0]  pair_count_reg, pair_count_next;
    logic [W-1:0]                  shift_reg, shift_next;
    irpwd_pkg::frame_status_t      status_reg, status_next;
    logic                          expect_mark_reg, expect_mark_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          decoded_reg, is_repeat_reg;
    logic [irpwd_pkg::PAIR_W-1:0]  bit_count_reg;
    logic [W-1:0]                  code_reg;

    logic                          res_ok, res_rep;
    logic [irpwd_pkg::PAIR_W-1:0]  res_bits, bits_sat;
    logic [W-1:0]                  res_code;
    logic                          frame_long;

    // A non-last item always drains; a last item needs the result slot
    assign item_pop = item_valid && (!item.last || !out_valid_reg || out_ready);

    // Frame step for the item at the head of the queue
    always_comb
    begin
        status_next      = status_reg;
        expect_mark_next = expect_mark_reg;
        pair_count_next  = pair_count_reg;
        shift_next       = shift_reg;
        if (status_reg == irpwd_pkg::ST_RUN)
        begin
            if (item_index_reg == '0)
            begin
                if (item.short_gap)
                    status_next = irpwd_pkg::ST_REPEAT;
            end
            else if (item_index_reg == irpwd_pkg::ITEM_W'(1)
                     || item_index_reg == irpwd_pkg::ITEM_W'(2))
            begin
                if (!item.hdr_mark)
                    status_next = irpwd_pkg::ST_FAIL;
            end
            else if (!expect_mark_reg)
            begin
                // A trailing space is not examined
                if (!item.last)
                begin
                    if (item.space_ok)
                        expect_mark_next = 1'b1;
                    else
                        status_next = irpwd_pkg::ST_STOP;
                end
            end
            else
            begin
                if (item.one_ok)
                    shift_next = {shift_reg[W-2:0], 1'b1};
                else if (item.zero_ok)
                    shift_next = {shift_reg[W-2:0], 1'b0};
                else
                    status_next = irpwd_pkg::ST_FAIL;
                if (pair_count_reg != irpwd_pkg::PAIR_MAX)
                    pair_count_next = pair_count_reg + 1'b1;
                expect_mark_next = 1'b0;
            end
        end
        item_index_next = (item_index_reg == irpwd_pkg::ITEM_MAX)
                          ? item_index_reg : item_index_reg + 1'b1;
    end

    // Frame verdict from the stepped state
    always_comb
    begin
        res_ok     = 1'b0;
        res_rep    = 1'b0;
        res_bits   = '0;
        res_code   = '0;
        frame_long = item_index_next >= irpwd_pkg::ITEM_W'(irpwd_pkg::MIN_FRAME_ITEMS);
        bits_sat   = (pair_count_next == irpwd_pkg::PAIR_MAX)
                     ? irpwd_pkg::PAIR_MAX : pair_count_next + 1'b1;
        if (frame_long && status_next != irpwd_pkg::ST_FAIL)
        begin
            if (status_next == irpwd_pkg::ST_REPEAT)
            begin
                res_ok   = 1'b1;
                res_rep  = 1'b1;
                res_code = '1;
            end
            else if (bits_sat >= irpwd_pkg::PAIR_W'(irpwd_pkg::MIN_BITS))
            begin
                res_ok   = 1'b1;
                res_bits = bits_sat;
                res_code = shift_next;
            end
        end
    end

    assign out_valid_next = (item_pop && item.last) ? 1'b1
                          : (out_ready ? 1'b0 : out_valid_reg);

    // Advance frame state; drop it back to idle after the last item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_index_reg  <= '0;
            pair_count_reg  <= '0;
            shift_reg       <= '0;
            status_reg      <= irpwd_pkg::ST_RUN;
            expect_mark_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (item_pop)
            begin
                if (item.last)
                begin
                    item_index_reg  <= '0;
                    pair_count_reg  <= '0;
                    shift_reg       <= '0;
                    status_reg      <= irpwd_pkg::ST_RUN;
                    expect_mark_reg <= 1'b0;
                end
                else
                begin
                    item_index_reg  <= item_index_next;
                    pair_count_reg  <= pair_count_next;
                    shift_reg       <= shift_next;
                    status_reg      <= status_next;
                    expect_mark_reg <= expect_mark_next;
                end
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (item_pop && item.last)
        begin
            decoded_reg   <= res_ok;
            is_repeat_reg <= res_rep;
            bit_count_reg <= res_bits;
            code_reg      <= res_code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign decoded    = decoded_reg;
    assign is_repeat  = is_repeat_reg;
    assign bit_count  = bit_count_reg;
    assign code_value = code_reg;

    `IRPWD_ASSERT_NXT(a_frame_clear,
        item_pop && item.last, item_index_reg == '0 && status_reg == irpwd_pkg::ST_RUN,
        "frame state not cleared after last item")
    `IRPWD_ASSERT_IMP(a_fail_empty,
        out_valid_reg && !decoded_reg, code_reg == '0 && bit_count_reg == '0,
        "failed frame carries data")
    `IRPWD_ASSERT_IMP(a_repeat_form,
        out_valid_reg && is_repeat_reg,
        decoded_reg && code_reg == '1 && bit_count_reg == '0,
        "repeat result malformed")

endmodule

`default_nettype wire

[hw/rtl/ir_pulse_width_frame_decoder.sv]
// Top level of the IR pulse-width frame decoder.
//
//  Channel  | Handshake                        | Payload
//  ---------+----------------------------------+----------------------------------------
//  input    | in_valid / in_ready              | duration_ticks, last_item
//  output   | out_valid / out_ready            | decoded, is_repeat, bit_count, code_value
//  config   | psel, penable, pwrite / pready   | paddr, pwdata, prdata
//
// With in_ready high one duration is accepted per cycle; the two-entry queue sustains it.
// out_valid is registered; it is set when the back end pops a frame's last duration.
// Only a last item waits on a held result; the queue then takes one more item.
// Reset is asynchronous, active low, and restores the default timing windows.
`default_nettype none

module ir_pulse_width_frame_decoder (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [irpwd_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [irpwd_pkg::DATA_W-1:0]         pwdata,
    output logic      [irpwd_pkg::DATA_W-1:0]         prdata,
    output logic                                      pready,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [irpwd_pkg::DUR_W-1:0]          duration_ticks,
    input  wire logic                                 last_item,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      decoded,
    output logic                                      is_repeat,
    output logic [irpwd_pkg::PAIR_W-1:0]              bit_count,
    output logic [irpwd_pkg::VALUE_WIDTH-1:0]         code_value
);

    irpwd_pkg::item_class_t front_class;
    irpwd_pkg::item_class_t head_class;
    logic                   q_not_full;
    logic                   q_valid;
    logic                   q_pop;

    assign in_ready = q_not_full;

    irpwd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .duration_ticks (duration_ticks),
        .last_item      (last_item),
        .item_class     (front_class)
    );

    irpwd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && q_not_full),
        .push_data (front_class),
        .not_full  (q_not_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_data  (head_class)
    );

    irpwd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item       (head_class),
        .item_pop   (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .decoded    (decoded),
        .is_repeat  (is_repeat),
        .bit_count  (bit_count),
        .code_value (code_value)
    );

endmodule

`default_nettype wire
